### sv/kmpq_pkg.sv
// Package for the keyed minimum priority queue.
// Holds command and status codes for the queue top level. No dependencies.
`default_nettype none
package kmpq_pkg;
    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_UPDATE   = 3'd2,
        CMD_POP      = 3'd3,
        CMD_PEEK     = 3'd4,
        CMD_CONTAINS = 3'd5,
        CMD_CLEAR    = 3'd6,
        CMD_NONE     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;
endpackage
`default_nettype wire

### sv/kmpq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module kmpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### sv/keyed_min_priority_queue_unit.sv
// Top level of the keyed minimum priority queue.
// Uses kmpq_pkg and two kmpq_ram instances (coordinates and keys).
//
// Usage: present a request on i_command / i_node_x / i_node_y / i_key_*
// with start high; it is taken at a clock edge where busy is low. Exactly
// one result follows, shown for one cycle with o_done high; the receiver
// cannot stall it. Entries live in two RAMs in insertion order.
// Flow after the accepting edge (n = entries held): insert, clear, an
// unknown code, or any request on an empty queue goes straight to the
// done state; contains and update scan until the first match or the
// last entry; peek and pop scan all n entries; pop and remove then
// compact the entries behind the removed one into the gap.
// The scan reads one RAM entry per cycle through the single read port;
// one request at a time. busy is low in the o_done cycle, so the next
// request can be taken while the result is shown.
// Reset clears the count and the controller; RAM contents are not cleared
// since only entries below the count ever reach a result.
`default_nettype none
module keyed_min_priority_queue_unit #(
    parameter int CAPACITY   = 256,
    parameter int COORD_BITS = 16,
    parameter int KEY_BITS   = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_command,
    input  wire logic [15:0] i_node_x,
    input  wire logic [15:0] i_node_y,
    input  wire logic [31:0] i_key_primary,
    input  wire logic [31:0] i_key_secondary,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic             o_found,
    output logic [15:0]      o_out_x,
    output logic [15:0]      o_out_y,
    output logic [31:0]      o_out_key_primary,
    output logic [31:0]      o_out_key_secondary,
    output logic [8:0]       o_occupancy
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int CRW = 2 * COORD_BITS;
    localparam int KW = 2 * KEY_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_DONE
    } t_state;

    t_state                r_state;
    kmpq_pkg::t_cmd        r_cmd;
    logic [CRW-1:0]        r_coords;
    logic [KW-1:0]         r_keys;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_ridx;     // address issued last cycle
    logic                  r_rvalid;   // RAM output holds entry r_ridx
    logic [CW-1:0]         r_best_idx;
    logic [CRW-1:0]        r_best_c;
    logic [KW-1:0]         r_best_k;
    logic                  r_have;
    logic [CW-1:0]         r_sh;       // next slot to fill during compaction

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [CRW-1:0]        c_wdata, c_rdata;
    logic [KW-1:0]         k_wdata, k_rdata;
    logic [CW-1:0]         n_raddr;

    kmpq_ram #(.WIDTH(CRW), .DEPTH(CAPACITY)) u_coords (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(c_wdata),
        .i_raddr(ram_raddr), .o_rdata(c_rdata)
    );
    kmpq_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_keys (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(k_wdata),
        .i_raddr(ram_raddr), .o_rdata(k_rdata)
    );

    assign busy = (r_state != S_IDLE);
    assign ram_raddr = n_raddr[AW-1:0];

    logic [CRW-1:0] in_coords;
    logic [KW-1:0]  in_keys;
    assign in_coords = {i_node_y[COORD_BITS-1:0], i_node_x[COORD_BITS-1:0]};
    assign in_keys   = {i_key_primary[KEY_BITS-1:0], i_key_secondary[KEY_BITS-1:0]};

    // Scan comparisons on the entry returned by the RAM.
    logic hit, less, scan_last;
    assign hit  = r_rvalid && (c_rdata == r_coords);
    assign less = r_rvalid && (!r_have || (k_rdata < r_best_k));
    assign scan_last = r_rvalid && (r_ridx + 1'b1 >= r_count);

    // Write port: insert from idle, update on hit, compaction copy in shift.
    logic in_go;
    assign in_go = start && !busy;
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        c_wdata   = in_coords;
        k_wdata   = in_keys;
        n_raddr   = '0;
        if (in_go) begin
            ram_we = (i_command == kmpq_pkg::CMD_INSERT) && (r_count < CW'(CAPACITY));
            n_raddr = '0;
        end else if (r_state == S_SCAN) begin
            n_raddr = r_ridx + 1'b1;
            if (r_cmd == kmpq_pkg::CMD_UPDATE && hit) begin
                ram_we    = 1'b1;
                ram_waddr = r_ridx[AW-1:0];
                c_wdata   = c_rdata;
                k_wdata   = r_keys;
            end
            // Popped entry found: start reading the entry behind it.
            if (scan_last && r_cmd == kmpq_pkg::CMD_POP)
                n_raddr = (less ? r_ridx : r_best_idx) + 1'b1;
            if (hit && r_cmd == kmpq_pkg::CMD_REMOVE)
                n_raddr = r_ridx + 1'b1;
        end else if (r_state == S_SHIFT) begin
            n_raddr   = r_sh + 2'd2;
            ram_we    = r_rvalid;
            ram_waddr = r_sh[AW-1:0];
            c_wdata   = c_rdata;
            k_wdata   = k_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rvalid <= 1'b0;
            o_done   <= 1'b0;
            r_cmd    <= kmpq_pkg::CMD_NONE;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_rvalid <= 1'b0;
                    if (in_go) begin
                        r_cmd      <= kmpq_pkg::t_cmd'(i_command);
                        r_coords   <= in_coords;
                        r_keys     <= in_keys;
                        r_have     <= 1'b0;
                        r_ridx     <= '0;
                        r_best_idx <= '0;
                        o_status   <= kmpq_pkg::ST_OK;
                        o_found    <= 1'b0;
                        o_out_x    <= '0;
                        o_out_y    <= '0;
                        o_out_key_primary   <= '0;
                        o_out_key_secondary <= '0;
                        r_state    <= S_DONE;
                        case (kmpq_pkg::t_cmd'(i_command))
                            kmpq_pkg::CMD_INSERT: begin
                                if (r_count >= CW'(CAPACITY))
                                    o_status <= kmpq_pkg::ST_FULL;
                                else
                                    r_count <= r_count + 1'b1;
                            end
                            kmpq_pkg::CMD_REMOVE, kmpq_pkg::CMD_UPDATE,
                            kmpq_pkg::CMD_CONTAINS: begin
                                if (r_count == '0) begin
                                    if (i_command != kmpq_pkg::CMD_CONTAINS)
                                        o_status <= kmpq_pkg::ST_NOT_FOUND;
                                end else begin
                                    r_rvalid <= 1'b1;
                                    r_state  <= S_SCAN;
                                end
                            end
                            kmpq_pkg::CMD_POP, kmpq_pkg::CMD_PEEK: begin
                                if (r_count == '0) begin
                                    o_status <= kmpq_pkg::ST_EMPTY;
                                    o_out_key_primary   <= 32'(KEY_BITS'('1));
                                    o_out_key_secondary <= 32'(KEY_BITS'('1));
                                end else begin
                                    r_rvalid <= 1'b1;
                                    r_state  <= S_SCAN;
                                end
                            end
                            kmpq_pkg::CMD_CLEAR: r_count <= '0;
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_ridx <= n_raddr;
                    if (r_cmd == kmpq_pkg::CMD_POP || r_cmd == kmpq_pkg::CMD_PEEK) begin
                        if (less) begin
                            r_have     <= 1'b1;
                            r_best_idx <= r_ridx;
                            r_best_c   <= c_rdata;
                            r_best_k   <= k_rdata;
                        end
                        if (scan_last) begin
                            o_out_x <= 16'(less ? c_rdata[COORD_BITS-1:0]
                                                : r_best_c[COORD_BITS-1:0]);
                            o_out_y <= 16'(less ? c_rdata[CRW-1:COORD_BITS]
                                                : r_best_c[CRW-1:COORD_BITS]);
                            o_out_key_primary   <= 32'(less ? k_rdata[KW-1:KEY_BITS]
                                                            : r_best_k[KW-1:KEY_BITS]);
                            o_out_key_secondary <= 32'(less ? k_rdata[KEY_BITS-1:0]
                                                            : r_best_k[KEY_BITS-1:0]);
                            if (r_cmd == kmpq_pkg::CMD_POP) begin
                                r_sh    <= less ? r_ridx : r_best_idx;
                                r_state <= S_SHIFT;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end else if (hit) begin
                        o_found <= (r_cmd == kmpq_pkg::CMD_CONTAINS);
                        if (r_cmd == kmpq_pkg::CMD_REMOVE) begin
                            r_sh    <= r_ridx;
                            r_state <= S_SHIFT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (scan_last) begin
                        if (r_cmd != kmpq_pkg::CMD_CONTAINS)
                            o_status <= kmpq_pkg::ST_NOT_FOUND;
                        r_state <= S_DONE;
                    end
                end
                S_SHIFT: begin
                    // Read of slot r_sh + 1 was issued last cycle; copy it down.
                    r_sh <= r_sh + 1'b1;
                    if (r_sh + 1'b1 >= r_count - 1'b1) begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_occupancy = 9'(r_count);

    // Show each result in the idle cycle that follows the done state.
    property p_done_from_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |-> r_state == S_IDLE;
    endproperty
    a_done_idle: assert property (p_done_from_idle) else $error("done outside idle");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count above capacity");

    a_busy_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> !o_done) else $error("done during scan");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held longer than one cycle");
endmodule
`default_nettype wire

### verif/keyed_min_priority_queue_unit_tb.sv
// Testbench for keyed_min_priority_queue_unit: random and directed requests,
// checked against a behavioral queue model kept in a scoreboard class.
// Depends on kmpq_pkg and the queue RTL only.
`timescale 1ns / 100ps
`default_nettype none
module keyed_min_priority_queue_unit_tb;

    localparam int DEPTH = 256;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [31:0] kp;
        logic [31:0] ks;
        logic [8:0]  occ;
    } t_reply;

    // Behavioral queue: predicts one reply per accepted request and holds
    // the replies that are still owed by the block.
    class queue_scoreboard;
        logic [31:0] coords[$];
        logic [63:0] keys[$];
        t_reply      owed[$];
        int          errors;

        function int find_cell(logic [31:0] c);
            int i;
            for (i = 0; i < coords.size(); i++)
                if (coords[i] == c) return i;
            return -1;
        endfunction

        function void note_request(kmpq_pkg::t_cmd cmd, logic [15:0] x, logic [15:0] y,
                                   logic [31:0] kp, logic [31:0] ks);
            t_reply r;
            int     pos;
            int     i;
            r = '0;
            case (cmd)
                kmpq_pkg::CMD_INSERT: begin
                    if (coords.size() >= DEPTH) r.status = kmpq_pkg::ST_FULL;
                    else begin
                        coords.insert(coords.size(), {y, x});
                        keys.insert(keys.size(), {kp, ks});
                    end
                end
                kmpq_pkg::CMD_REMOVE, kmpq_pkg::CMD_UPDATE: begin
                    pos = find_cell({y, x});
                    if (pos < 0) r.status = kmpq_pkg::ST_NOT_FOUND;
                    else if (cmd == kmpq_pkg::CMD_UPDATE) keys[pos] = {kp, ks};
                    else begin
                        coords.delete(pos);
                        keys.delete(pos);
                    end
                end
                kmpq_pkg::CMD_POP, kmpq_pkg::CMD_PEEK: begin
                    if (coords.size() == 0) begin
                        r.status = kmpq_pkg::ST_EMPTY;
                        r.kp = '1;
                        r.ks = '1;
                    end else begin
                        // strict less keeps the earliest entry on a tie
                        pos = 0;
                        for (i = 1; i < keys.size(); i++)
                            if (keys[i] < keys[pos]) pos = i;
                        {r.oy, r.ox} = coords[pos];
                        {r.kp, r.ks} = keys[pos];
                        if (cmd == kmpq_pkg::CMD_POP) begin
                            coords.delete(pos);
                            keys.delete(pos);
                        end
                    end
                end
                kmpq_pkg::CMD_CONTAINS: r.found = (find_cell({y, x}) >= 0);
                kmpq_pkg::CMD_CLEAR: begin
                    coords.delete();
                    keys.delete();
                end
                default: ;
            endcase
            r.occ = 9'(coords.size());
            owed.insert(owed.size(), r);
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected reply %h", $time, got);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.status != want.status) begin
                $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.found != want.found) begin
                $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
                errors++;
            end
            if (got.ox != want.ox || got.oy != want.oy) begin
                $display("%0t: cell exp %h/%h got %h/%h", $time,
                         want.ox, want.oy, got.ox, got.oy);
                errors++;
            end
            if (got.kp != want.kp || got.ks != want.ks) begin
                $display("%0t: keys exp %h/%h got %h/%h", $time,
                         want.kp, want.ks, got.kp, got.ks);
                errors++;
            end
            if (got.occ != want.occ) begin
                $display("%0t: occupancy exp %0d got %0d", $time, want.occ, got.occ);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_command;
    logic [15:0] i_node_x;
    logic [15:0] i_node_y;
    logic [31:0] i_key_primary;
    logic [31:0] i_key_secondary;
    logic        o_done;
    logic [1:0]  o_status;
    logic        o_found;
    logic [15:0] o_out_x;
    logic [15:0] o_out_y;
    logic [31:0] o_out_key_primary;
    logic [31:0] o_out_key_secondary;
    logic [8:0]  o_occupancy;

    keyed_min_priority_queue_unit dut (.*);

    queue_scoreboard board;
    int              idle_pct;
    longint          cycle_count = 0;
    // small coordinate pool so remove/update/contains mostly hit
    logic [15:0]     pool_x[8];
    logic [15:0]     pool_y[8];

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check each reply at the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            board.check_reply({o_status, o_found, o_out_x, o_out_y,
                               o_out_key_primary, o_out_key_secondary, o_occupancy});
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Issue one request; hold start until the block takes it. start stays
    // high after the accept and drops only in an idle cycle.
    task automatic send_request(kmpq_pkg::t_cmd cmd, logic [15:0] x, logic [15:0] y,
                                logic [31:0] kp, logic [31:0] ks);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= cmd;
        i_node_x        <= x;
        i_node_y        <= y;
        i_key_primary   <= kp;
        i_key_secondary <= ks;
        do @(posedge i_clk); while (busy);
        board.note_request(cmd, x, y, kp, ks);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(5))
            0: pick_key = '1;
            1: pick_key = '0;
            2: pick_key = $urandom_range(3);
            default: pick_key = $urandom;
        endcase
    endfunction

    task automatic random_request(int fill_bias);
        int             r;
        int             p;
        logic [15:0]    x;
        logic [15:0]    y;
        kmpq_pkg::t_cmd cmd;
        r = $urandom_range(99);
        p = $urandom_range(7);
        x = pool_x[p];
        y = pool_y[p];
        if ($urandom_range(9) == 0) begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
        if (r < fill_bias)  cmd = kmpq_pkg::CMD_INSERT;
        else if (r < 55)    cmd = kmpq_pkg::CMD_POP;
        else if (r < 65)    cmd = kmpq_pkg::CMD_REMOVE;
        else if (r < 75)    cmd = kmpq_pkg::CMD_UPDATE;
        else if (r < 84)    cmd = kmpq_pkg::CMD_PEEK;
        else if (r < 93)    cmd = kmpq_pkg::CMD_CONTAINS;
        else if (r < 96)    cmd = kmpq_pkg::CMD_NONE;
        else cmd = (board.coords.size() > 40) ? kmpq_pkg::CMD_CLEAR : kmpq_pkg::CMD_INSERT;
        send_request(cmd, x, y, pick_key(), pick_key());
    endtask

    initial begin
        int i;
        int k;
        board       = new();
        idle_pct    = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_command   = kmpq_pkg::CMD_NONE;
        i_node_x    = '0;
        i_node_y    = '0;
        i_key_primary   = '0;
        i_key_secondary = '0;
        for (i = 0; i < 8; i++) begin
            pool_x[i] = (i == 0) ? 16'hFFFF : 16'($urandom);
            pool_y[i] = (i == 1) ? 16'hFFFF : 16'($urandom);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, ties, extremes, every command, unknown code.
        send_request(kmpq_pkg::CMD_POP, '0, '0, '0, '0);
        send_request(kmpq_pkg::CMD_PEEK, '0, '0, '0, '0);
        send_request(kmpq_pkg::CMD_REMOVE, 16'd1, 16'd2, '0, '0);
        send_request(kmpq_pkg::CMD_UPDATE, 16'd1, 16'd2, '0, '0);
        send_request(kmpq_pkg::CMD_CONTAINS, 16'd1, 16'd2, '0, '0);
        send_request(kmpq_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, '1, '1);
        send_request(kmpq_pkg::CMD_INSERT, '0, '0, 32'd5, 32'd7);
        send_request(kmpq_pkg::CMD_INSERT, 16'd3, 16'd3, 32'd5, 32'd7);
        send_request(kmpq_pkg::CMD_INSERT, '0, '0, 32'd5, 32'd6);
        send_request(kmpq_pkg::CMD_PEEK, '0, '0, '0, '0);
        send_request(kmpq_pkg::CMD_UPDATE, '0, '0, 32'd5, 32'd5);
        send_request(kmpq_pkg::CMD_CONTAINS, 16'hFFFF, 16'hFFFF, '0, '0);
        send_request(kmpq_pkg::CMD_POP, '0, '0, '0, '0);
        send_request(kmpq_pkg::CMD_REMOVE, 16'd3, 16'd3, '0, '0);
        send_request(kmpq_pkg::CMD_NONE, 16'hFFFF, 16'hFFFF, '1, '1);
        send_request(kmpq_pkg::CMD_CLEAR, '0, '0, '0, '0);
        send_request(kmpq_pkg::CMD_PEEK, '0, '0, '0, '0);
        // Fill to capacity and overflow once.
        for (i = 0; i <= DEPTH; i++)
            send_request(kmpq_pkg::CMD_INSERT, 16'($urandom), 16'($urandom),
                         32'($urandom_range(15)), 32'($urandom));
        send_request(kmpq_pkg::CMD_POP, '0, '0, '0, '0);
        send_request(kmpq_pkg::CMD_CLEAR, '0, '0, '0, '0);

        // Random phases: no idling, heavy idling, light idling, none again.
        for (k = 0; k < 4; k++) begin
            case (k)
                0: idle_pct = 0;
                1: idle_pct = 64;
                2: idle_pct = 9;
                default: idle_pct = 0;
            endcase
            for (i = 0; i < 380; i++)
                random_request((k == 3) ? 45 : 35);
        end
        start <= 1'b0;

        while (board.owed.size() != 0 && cycle_count < 3900000)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
